// ===== src/ddir_pkg.sv =====
// ----------------------------------------------------------------------------
// ddir_pkg
// Types and constants shared by the disc DMA interface register block.
// ----------------------------------------------------------------------------
package ddir_pkg;

   // request kinds (carried on req_tuser)
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register byte offsets
   localparam logic [5:0] OFS_STATUS  = 6'h00;
   localparam logic [5:0] OFS_COVER   = 6'h04;
   localparam logic [5:0] OFS_CMD0    = 6'h08;
   localparam logic [5:0] OFS_CMD1    = 6'h0C;
   localparam logic [5:0] OFS_CMD2    = 6'h10;
   localparam logic [5:0] OFS_DMA_ADR = 6'h14;
   localparam logic [5:0] OFS_DMA_LEN = 6'h18;
   localparam logic [5:0] OFS_DMA_CTL = 6'h1C;
   localparam logic [5:0] OFS_IMM     = 6'h20;
   localparam logic [5:0] OFS_CONFIG  = 6'h24;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISC_PRESENT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISC_SIZE    = 1'd1;
   localparam int unsigned CSR_DATA_WIDTH = 34;

   // status bits
   localparam logic [6:0] ST_CLEAR_BITS = 7'h54;
   localparam logic [6:0] ST_MASK_BITS  = 7'h2A;
   localparam logic [6:0] ST_ERROR      = 7'h04;
   localparam logic [6:0] ST_DONE       = 7'h10;
   localparam int unsigned ST_DONE_MASK_BIT = 3;
   localparam int unsigned ST_DONE_BIT      = 4;

   localparam logic [7:0]  CMD_READ  = 8'hA8;
   localparam logic [31:0] ADDR_MASK = 32'h03FF_FFE0;
   localparam logic [31:0] LEN_MASK  = ~32'h0000_001F;
   localparam logic [2:0]  CTRL_MASK = 3'h7;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  byte_offset;
      logic [31:0] write_data;
      logic        buffer_ok;
      logic        source_read_ok;
   } req_type;

   typedef struct packed {
      logic [33:0] disc_byte_offset;
      logic [25:0] dma_target;
      logic        transfer_ok;
      logic        transfer_finished;
      logic        irq;
      logic [31:0] read_data;
   } rsp_type;

endpackage

// ===== src/ddir_core.sv =====
// ----------------------------------------------------------------------------
// ddir_core
// Register file and transfer check; result is combinational from the request.
// ----------------------------------------------------------------------------
module ddir_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_take,
   input  ddir_pkg::req_type                       req,
   input  logic                                    csr_take,
   input  logic [ddir_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ddir_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output ddir_pkg::rsp_type                       rsp
);
   import ddir_pkg::*;

   logic        disc_present_ff, disc_present_in;
   logic [33:0] disc_size_ff, disc_size_in;
   logic [6:0]  status_ff, status_in;
   logic [31:0] cmd0_ff, cmd0_in;
   logic [31:0] cmd1_ff, cmd1_in;
   logic [31:0] cmd2_ff, cmd2_in;
   logic [25:0] dma_adr_ff, dma_adr_in;
   logic [31:0] dma_len_ff, dma_len_in;
   logic [2:0]  dma_ctl_ff, dma_ctl_in;
   logic [31:0] imm_ff, imm_in;
   logic        pending_ff, pending_in;

   logic [33:0] boff;
   logic [34:0] range_end;
   logic        good;
   logic [31:0] rd;
   logic [2:0]  ctl_wr;

   assign boff      = {cmd1_ff, 2'b00};
   assign range_end = {1'b0, boff} + {3'b000, dma_len_ff};
   assign good      = (cmd0_ff[31:24] == CMD_READ) && disc_present_ff && req.buffer_ok
                      && (range_end <= {1'b0, disc_size_ff}) && req.source_read_ok;
   assign ctl_wr    = req.write_data[2:0] & CTRL_MASK;

   // register read mux
   always_comb begin
      case (req.byte_offset)
         OFS_STATUS:  rd = {25'd0, status_ff};
         OFS_COVER:   rd = {31'd0, ~disc_present_ff};
         OFS_CMD0:    rd = cmd0_ff;
         OFS_CMD1:    rd = cmd1_ff;
         OFS_CMD2:    rd = cmd2_ff;
         OFS_DMA_ADR: rd = {6'd0, dma_adr_ff};
         OFS_DMA_LEN: rd = dma_len_ff;
         OFS_DMA_CTL: rd = {29'd0, dma_ctl_ff};
         OFS_IMM:     rd = imm_ff;
         OFS_CONFIG:  rd = 32'd1;
         default:     rd = 32'd0;
      endcase
   end

   always_comb begin
      disc_present_in = disc_present_ff;
      disc_size_in    = disc_size_ff;
      status_in       = status_ff;
      cmd0_in         = cmd0_ff;
      cmd1_in         = cmd1_ff;
      cmd2_in         = cmd2_ff;
      dma_adr_in      = dma_adr_ff;
      dma_len_in      = dma_len_ff;
      dma_ctl_in      = dma_ctl_ff;
      imm_in          = imm_ff;
      pending_in      = pending_ff;
      rsp             = '0;

      if (csr_take) begin
         case (csr_index)
            CSR_DISC_PRESENT: disc_present_in = csr_data[0];
            CSR_DISC_SIZE:    disc_size_in    = csr_data;
            default: ;
         endcase
      end

      if (req_take) begin
         case (req.operation)
            OP_READ: rsp.read_data = rd;
            OP_WRITE: begin
               case (req.byte_offset)
                  OFS_STATUS: begin
                     // write-one-to-clear flags, mask bits follow the data
                     status_in = (status_ff & ~(req.write_data[6:0] & ST_CLEAR_BITS)
                                  & ~ST_MASK_BITS) | (req.write_data[6:0] & ST_MASK_BITS);
                  end
                  OFS_CMD0:    cmd0_in    = req.write_data;
                  OFS_CMD1:    cmd1_in    = req.write_data;
                  OFS_CMD2:    cmd2_in    = req.write_data;
                  OFS_DMA_ADR: dma_adr_in = req.write_data[25:0] & ADDR_MASK[25:0];
                  OFS_DMA_LEN: dma_len_in = req.write_data & LEN_MASK;
                  OFS_DMA_CTL: begin
                     dma_ctl_in = ctl_wr;
                     if (ctl_wr[0]) begin
                        pending_in = 1'b1;
                     end
                  end
                  OFS_IMM:     imm_in     = req.write_data;
                  default: ;
               endcase
            end
            OP_TICK: begin
               if (pending_ff) begin
                  pending_in                = 1'b0;
                  dma_ctl_in                = dma_ctl_ff & 3'b110;
                  dma_len_in                = 32'd0;
                  status_in                 = status_ff | (good ? ST_DONE : ST_ERROR);
                  rsp.transfer_finished     = 1'b1;
                  rsp.transfer_ok           = good;
                  rsp.dma_target            = dma_adr_ff;
                  rsp.disc_byte_offset      = boff;
               end
            end
            default: ;
         endcase
      end

      rsp.irq = status_in[ST_DONE_MASK_BIT] & status_in[ST_DONE_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_present_ff <= 1'b0;
         disc_size_ff    <= '0;
         status_ff       <= '0;
         cmd0_ff         <= '0;
         cmd1_ff         <= '0;
         cmd2_ff         <= '0;
         dma_adr_ff      <= '0;
         dma_len_ff      <= '0;
         dma_ctl_ff      <= '0;
         imm_ff          <= '0;
         pending_ff      <= 1'b0;
      end else begin
         disc_present_ff <= disc_present_in;
         disc_size_ff    <= disc_size_in;
         status_ff       <= status_in;
         cmd0_ff         <= cmd0_in;
         cmd1_ff         <= cmd1_in;
         cmd2_ff         <= cmd2_in;
         dma_adr_ff      <= dma_adr_in;
         dma_len_ff      <= dma_len_in;
         dma_ctl_ff      <= dma_ctl_in;
         imm_ff          <= imm_in;
         pending_ff      <= pending_in;
      end
   end

endmodule

// ===== src/disc_dma_interface_registers.sv =====
// ----------------------------------------------------------------------------
// disc_dma_interface_registers
// Register block of a disc DMA interface with stream request/response ports.
// ----------------------------------------------------------------------------
// Every request (register read, register write or scheduler tick) gives
// exactly one response. The register file updates on the accepting edge
// and the response lands in the output register, so one request per cycle
// is sustained while rsp_tready is high. A two-entry output buffer (output
// register plus skid) lets a request be accepted while the previous
// response is still waiting; req_tready drops only when both entries are
// full. A tick with an armed transfer checks the command (read, 0xA8), disc
// presence, buffer_ok, source_read_ok and the byte range against the disc
// size, then raises the done or error flag. irq in each response is the
// done flag AND its mask after that request. Configuration (disc present,
// disc size) is written through the csr_ port, which is always ready.
// ----------------------------------------------------------------------------
module disc_dma_interface_registers (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [5:0] byte_offset, [37:6] write_data, [38] buffer_ok, [39] source_read_ok
   input  logic [39:0]                           req_tdata,
   // [1:0] operation
   input  logic [1:0]                            req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] read_data, [32] irq, [33] transfer_finished, [34] transfer_ok,
   // [60:35] dma_target, [94:61] disc_byte_offset, [95] zero
   output logic [95:0]                           rsp_tdata,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddir_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ddir_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import ddir_pkg::*;

   req_type req;
   rsp_type core_rsp;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    req_take;
   logic    rsp_take;

   assign req.operation      = req_tuser;
   assign req.byte_offset    = req_tdata[5:0];
   assign req.write_data     = req_tdata[37:6];
   assign req.buffer_ok      = req_tdata[38];
   assign req.source_read_ok = req_tdata[39];

   assign req_tready = ~skid_valid_ff;
   assign req_take   = req_tvalid & req_tready;
   assign rsp_take   = out_valid_ff & rsp_tready;
   assign csr_ready  = 1'b1;

   ddir_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req       (req),
      .csr_take  (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp       (core_rsp)
   );

   // output register + skid; skid only fills when the output is stalled
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = core_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = core_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.disc_byte_offset, out_ff.dma_target,
                        out_ff.transfer_ok, out_ff.transfer_finished, out_ff.irq,
                        out_ff.read_data};

   // skid entry is only ever used behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   // a stalled response is never dropped
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff)
      else $error("stalled response lost");

   // only an armed tick may finish a transfer
   a_finish_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_take && core_rsp.transfer_finished) |-> (req_tuser == OP_TICK))
      else $error("transfer finished on a non-tick request");

   // success is only reported with a finished transfer
   a_ok_needs_finish: assert property (@(posedge clock) disable iff (reset)
      (req_take && core_rsp.transfer_ok) |-> core_rsp.transfer_finished)
      else $error("transfer_ok without transfer_finished");

endmodule

// ===== tb/tb_disc_dma_interface_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disc_dma_interface_registers
// Self-checking bench for the disc DMA interface register block: directed
// register and transfer cases, then randomised transfer sequences and noise
// under several disc settings, scored against a behavioural register model.
// ----------------------------------------------------------------------------
module tb_disc_dma_interface_registers;
   import ddir_pkg::*;

   // operation code that the block must treat as a no-op
   localparam logic [1:0] OP_IDLE     = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam logic [33:0] SIZE_MAX   = 34'h3_FFFF_FFFF;

   // -------------------------------------------------------------------------
   // Register model and expected-response store
   // -------------------------------------------------------------------------
   class ddir_register_model;
      logic        present;
      logic [33:0] disc_size;
      logic [6:0]  status;
      logic [31:0] cmd [3];
      logic [25:0] dma_adr;
      logic [31:0] dma_len;
      logic [2:0]  dma_ctl;
      logic [31:0] imm;
      logic        armed;
      rsp_type     awaited [$];
      int unsigned mismatches;

      function new();
         present    = 1'b0;
         disc_size  = '0;
         status     = '0;
         foreach (cmd[i]) cmd[i] = '0;
         dma_adr    = '0;
         dma_len    = '0;
         dma_ctl    = '0;
         imm        = '0;
         armed      = 1'b0;
         mismatches = 0;
      endfunction

      function void configure(logic [CSR_INDEX_WIDTH-1:0] idx,
                              logic [CSR_DATA_WIDTH-1:0] value);
         if (idx == CSR_DISC_PRESENT) begin
            present = value[0];
         end else if (idx == CSR_DISC_SIZE) begin
            disc_size = value;
         end
      endfunction

      // work out the response to one accepted request and queue it
      function void note_request(req_type rq);
         rsp_type     e;
         logic [33:0] boff;
         logic        good;
         logic [31:0] v;
         e = '0;
         v = rq.write_data;
         case (rq.operation)
            OP_READ: begin
               case (rq.byte_offset)
                  OFS_STATUS:  e.read_data = {25'd0, status};
                  OFS_COVER:   e.read_data = {31'd0, ~present};
                  OFS_CMD0:    e.read_data = cmd[0];
                  OFS_CMD1:    e.read_data = cmd[1];
                  OFS_CMD2:    e.read_data = cmd[2];
                  OFS_DMA_ADR: e.read_data = {6'd0, dma_adr};
                  OFS_DMA_LEN: e.read_data = dma_len;
                  OFS_DMA_CTL: e.read_data = {29'd0, dma_ctl};
                  OFS_IMM:     e.read_data = imm;
                  OFS_CONFIG:  e.read_data = 32'd1;
                  default:     e.read_data = '0;
               endcase
            end
            OP_WRITE: begin
               case (rq.byte_offset)
                  OFS_STATUS: begin
                     // write-one-to-clear flags, mask bits follow the data
                     status = (status & ~(v[6:0] & ST_CLEAR_BITS) & ~ST_MASK_BITS)
                              | (v[6:0] & ST_MASK_BITS);
                  end
                  OFS_CMD0:    cmd[0] = v;
                  OFS_CMD1:    cmd[1] = v;
                  OFS_CMD2:    cmd[2] = v;
                  OFS_DMA_ADR: dma_adr = v[25:0] & ADDR_MASK[25:0];
                  OFS_DMA_LEN: dma_len = v & LEN_MASK;
                  OFS_DMA_CTL: begin
                     dma_ctl = v[2:0] & CTRL_MASK;
                     if (dma_ctl[0]) armed = 1'b1;
                  end
                  OFS_IMM:     imm = v;
                  default: ;
               endcase
            end
            OP_TICK: begin
               if (armed) begin
                  boff = {cmd[1], 2'b00};
                  good = (cmd[0][31:24] == CMD_READ) && present && rq.buffer_ok
                         && (boff <= disc_size)
                         && ({2'b00, dma_len} <= disc_size - boff)
                         && rq.source_read_ok;
                  e.transfer_finished = 1'b1;
                  e.transfer_ok       = good;
                  e.dma_target        = dma_adr;
                  e.disc_byte_offset  = boff;
                  armed      = 1'b0;
                  dma_ctl[0] = 1'b0;
                  dma_len    = '0;
                  status     = status | (good ? ST_DONE : ST_ERROR);
               end
            end
            default: ;
         endcase
         e.irq = status[ST_DONE_MASK_BIT] & status[ST_DONE_BIT];
         awaited.push_back(e);
      endfunction

      function void field_check(string name, logic [33:0] want_v, logic [33:0] got_v);
         if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_response(logic [95:0] raw);
         rsp_type got;
         rsp_type want;
         got = raw[94:0];
         if (awaited.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual %h", $time, raw);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         field_check("read_data", want.read_data, got.read_data);
         field_check("irq", want.irq, got.irq);
         field_check("transfer_finished", want.transfer_finished, got.transfer_finished);
         field_check("transfer_ok", want.transfer_ok, got.transfer_ok);
         field_check("dma_target", want.dma_target, got.dma_target);
         field_check("disc_byte_offset", want.disc_byte_offset, got.disc_byte_offset);
         field_check("pad bit", 34'd0, raw[95]);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   // [5:0] byte_offset, [37:6] write_data, [38] buffer_ok, [39] source_read_ok
   logic [39:0]                req_tdata;
   // [1:0] operation
   logic [1:0]                 req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   // [31:0] read_data, [32] irq, [33] transfer_finished, [34] transfer_ok,
   // [60:35] dma_target, [94:61] disc_byte_offset, [95] zero
   logic [95:0]                rsp_tdata;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   ddir_register_model regs_model = new();

   bit          calm;           // no idling on either side while set
   int          rsp_hold;       // cycles the response side still holds off
   int unsigned requests_sent;
   int unsigned cycle_count;
   logic [33:0] cur_size;

   disc_dma_interface_registers u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Monitor: every handshake is sampled at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_type rq;
      if (!reset) begin
         // a request sees the configuration from before this edge
         if (req_tvalid && req_tready) begin
            rq.operation      = req_tuser;
            rq.byte_offset    = req_tdata[5:0];
            rq.write_data     = req_tdata[37:6];
            rq.buffer_ok      = req_tdata[38];
            rq.source_read_ok = req_tdata[39];
            regs_model.note_request(rq);
         end
         if (csr_valid && csr_ready) regs_model.configure(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) regs_model.check_response(rsp_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Response side: random back-pressure, a calm stretch, and long hold-offs
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 34);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side tasks; all are entered and left at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_request(input logic [1:0] op, input logic [5:0] ofs,
                               input logic [31:0] wd, input logic bok,
                               input logic sok);
      while (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sok, bok, wd, ofs};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic drop_request();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending and let every outstanding response drain
   task automatic drain();
      drop_request();
      while (regs_model.awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_disc(input logic present, input logic [33:0] size);
      write_csr(CSR_DISC_PRESENT, {33'd0, present});
      write_csr(CSR_DISC_SIZE, size);
      cur_size = size;
   endtask

   // any request at all: mostly aligned offsets, some anywhere in the window
   task automatic noise_request();
      logic [1:0] op;
      logic [5:0] ofs;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_READ;
      else if (pick < 85) op = OP_WRITE;
      else if (pick < 97) op = OP_TICK;
      else                op = OP_IDLE;
      if ($urandom_range(99) < 85) ofs = 6'($urandom_range(9) * 4);
      else                         ofs = 6'($urandom_range(63));
      send_request(op, ofs, $urandom, 1'($urandom), 1'($urandom));
   endtask

   // a well-formed transfer: command, offset, length, address, start, tick
   task automatic transfer_sequence();
      int unsigned scale;
      logic [31:0] c0, c1, len;
      scale = (cur_size > 34'd65536) ? 65536 : int'(cur_size[16:0]);
      c0 = ($urandom_range(99) < 80) ? {CMD_READ, 24'($urandom)} : $urandom;
      if ($urandom_range(99) < 20) begin
         // range right at the end of the disc, or one block past it
         c1  = $urandom_range(scale / 4);
         len = (scale - 4 * c1) & LEN_MASK;
         if ($urandom_range(1)) len = len + 32;
      end else begin
         c1  = ($urandom_range(99) < 25) ? $urandom : $urandom_range(scale / 4 + 8);
         len = ($urandom_range(99) < 25) ? $urandom : $urandom_range(scale + 64);
      end
      send_request(OP_WRITE, OFS_CMD0, c0, 1'($urandom), 1'($urandom));
      send_request(OP_WRITE, OFS_CMD1, c1, 1'($urandom), 1'($urandom));
      send_request(OP_WRITE, OFS_DMA_LEN, len, 1'($urandom), 1'($urandom));
      if ($urandom_range(1))
         send_request(OP_WRITE, OFS_DMA_ADR, $urandom, 1'($urandom), 1'($urandom));
      send_request(OP_WRITE, OFS_DMA_CTL, $urandom | 32'd1, 1'($urandom), 1'($urandom));
      if ($urandom_range(99) < 10)
         send_request(OP_WRITE, OFS_DMA_CTL, $urandom | 32'd1, 1'b0, 1'b0);
      if ($urandom_range(1))
         send_request(OP_READ, OFS_DMA_LEN, $urandom, 1'($urandom), 1'($urandom));
      if ($urandom_range(99) < 95)
         send_request(OP_TICK, 6'($urandom), $urandom,
                      $urandom_range(99) < 85, $urandom_range(99) < 85);
      send_request(OP_READ, OFS_STATUS, $urandom, 1'($urandom), 1'($urandom));
      // acknowledge flags and reprogram masks now and then
      if ($urandom_range(1))
         send_request(OP_WRITE, OFS_STATUS, $urandom, 1'($urandom), 1'($urandom));
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         if ($urandom_range(99) < 70) transfer_sequence();
         else                         noise_request();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [63:0] r64;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_READ;
      csr_valid     = 1'b0;
      csr_index     = CSR_DISC_PRESENT;
      csr_data      = '0;
      calm          = 1'b0;
      rsp_hold      = 0;
      requests_sent = 0;
      cur_size      = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, read-only and unknown offsets, error paths
      send_request(OP_READ, OFS_STATUS, '0, 1'b0, 1'b0);       // reset value
      drain();
      set_disc(1'b1, SIZE_MAX);
      send_request(OP_WRITE, OFS_STATUS, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_request(OP_WRITE, OFS_CMD0, 32'hA800_0000, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_CMD1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_CMD2, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_ADR, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_LEN, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_CTL, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_COVER, 32'hFFFF_FFFF, 1'b0, 1'b0);  // read-only
      send_request(OP_WRITE, OFS_CONFIG, 32'hFFFF_FFFF, 1'b0, 1'b0); // read-only
      send_request(OP_WRITE, 6'h03, 32'hFFFF_FFFF, 1'b0, 1'b0);      // unaligned
      send_request(OP_WRITE, 6'h3F, 32'hFFFF_FFFF, 1'b0, 1'b0);      // unknown
      send_request(OP_IDLE, OFS_STATUS, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // range runs off the end of the disc: error flag
      send_request(OP_TICK, OFS_STATUS, '0, 1'b1, 1'b1);
      send_request(OP_WRITE, OFS_CMD1, '0, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_LEN, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_CTL, 32'd1, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_CTL, 32'd1, 1'b0, 1'b0);       // repeated start
      send_request(OP_TICK, OFS_STATUS, '0, 1'b1, 1'b1);           // succeeds, irq
      send_request(OP_TICK, OFS_STATUS, '0, 1'b1, 1'b1);           // nothing armed
      send_request(OP_READ, OFS_COVER, '0, 1'b0, 1'b0);
      send_request(OP_READ, OFS_DMA_CTL, '0, 1'b0, 1'b0);
      send_request(OP_READ, OFS_CONFIG, '0, 1'b0, 1'b0);
      send_request(OP_READ, 6'h3F, '0, 1'b0, 1'b0);
      // a command other than read fails
      send_request(OP_WRITE, OFS_CMD0, 32'h1200_0000, 1'b0, 1'b0);
      send_request(OP_WRITE, OFS_DMA_CTL, 32'd1, 1'b0, 1'b0);
      send_request(OP_TICK, OFS_STATUS, '0, 1'b1, 1'b1);
      drain();

      // small disc; response side holds off long enough to back up requests
      set_disc(1'b1, 34'd4096);
      rsp_hold = 150;
      run_phase(150);
      // sender pauses until everything is back, then carries on
      drop_request();
      while (regs_model.awaited.size() != 0) @(negedge clock);
      run_phase(150);
      drain();

      // no disc attached
      r64 = {$urandom, $urandom};
      set_disc(1'b0, r64[33:0]);
      run_phase(250);
      drain();

      // empty disc, with neither side idling
      set_disc(1'b1, '0);
      calm = 1'b1;
      run_phase(250);
      drain();
      calm = 1'b0;

      set_disc(1'b1, SIZE_MAX);
      run_phase(300);
      drain();

      r64 = {$urandom, $urandom};
      set_disc(1'b1, r64[33:0]);
      run_phase(300);
      drain();

      set_disc(1'b1, 34'($urandom_range(20000, 64)));
      run_phase(300);
      drain();

      set_disc(1'b1, 34'd16384);
      run_phase(250);
      drain();

      repeat (20) @(negedge clock);
      if (regs_model.mismatches == 0 && regs_model.awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ddir_pkg.sv
src/ddir_core.sv
src/disc_dma_interface_registers.sv
tb/tb_disc_dma_interface_registers.sv
